[sv/png_scanline_unfilter_macros.svh]
// assertion macros shared by the png scanline unfilter rtl
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PNGSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PNGSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pngsu_pkg.sv]
// types, register map and predictor functions for the png scanline unfilter
package pngsu_pkg;

	// config register field widths
	localparam int ROW_BYTES_W   = 14;
	localparam int PIXEL_BYTES_W = 4;
	localparam int IMAGE_ROWS_W  = 16;

	// config register index, taken from paddr[3:2]
	localparam logic [1:0] REG_ROW_BYTES   = 2'd0;
	localparam logic [1:0] REG_PIXEL_BYTES = 2'd1;
	localparam logic [1:0] REG_IMAGE_ROWS  = 2'd2;

	// largest defined filter code
	localparam logic [7:0] FILT_MAX_CODE = 8'd4;

	// png filter types
	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	// one stream item as it sits in the read stage
	typedef struct packed {
		logic       is_data;
		logic [7:0] value;
		filt_t      filt;
		logic       top_row;
		logic       eor;
		logic       eoi;
	} s1_item_t;

	// average of left and above, sum kept at 9 bits
	function automatic logic [7:0] avg_pred(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[8:1];
	endfunction

	// paeth predictor, ties go to left, then above, then upper-left
	function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		logic [9:0] ab;
		logic [9:0] cc;
		pa = (b >= c) ? {2'b00, b - c} : {2'b00, c - b};
		pb = (a >= c) ? {2'b00, a - c} : {2'b00, c - a};
		ab = {2'b00, a} + {2'b00, b};
		cc = {1'b0, c, 1'b0};
		pc = (ab >= cc) ? (ab - cc) : (cc - ab);
		if ((pa <= pb) && (pa <= pc)) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

endpackage

[sv/png_scanline_unfilter.sv]
// top level of the png scanline unfilter: config regs, row tracking, predictor
//
//  channel  | signals                                  | moves
//  ---------+------------------------------------------+-----------------------------
//  byte     | byte_valid, byte_ready, in_byte          | filter code or filtered data
//  res      | res_valid, res_ready, out_byte,          | one reconstructed data item
//           | end_of_row, end_of_image                 |
//  apb      | psel, penable, pwrite, paddr, pwdata ... | row_bytes, pixel_bytes, rows
//
// one item per cycle unless results stall; data moves from read stage to output register.
// the line buffer is read when an item is taken and written back as it leaves the read stage.
// a filter-code item gives no result and never stalls in the read stage.
// reset clears counters, the left and upper-left bytes and the pipeline valids;
// the line buffer is not cleared; row 0 ignores what it reads.
// a stalled result holds a data item in the read stage and byte_ready stays low until it moves.
`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter import pngsu_pkg::*; #(
	parameter int MAX_ROW_BYTES   = 8192,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// stream in
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  in_byte,
	// results out
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  out_byte,
	output logic        end_of_row,
	output logic        end_of_image
);

	localparam int AW  = $clog2(MAX_ROW_BYTES);
	localparam int CW  = $clog2(MAX_ROW_BYTES + 1);
	localparam int PW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int RBW = (CW > ROW_BYTES_W) ? CW : ROW_BYTES_W;
	localparam logic [RBW-1:0]           MAX_RB = RBW'(MAX_ROW_BYTES);
	localparam logic [PIXEL_BYTES_W-1:0] MAX_PB = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);

	// config registers
	logic [ROW_BYTES_W-1:0]   row_bytes_q;
	logic [PIXEL_BYTES_W-1:0] pixel_bytes_q;
	logic [IMAGE_ROWS_W-1:0]  image_rows_q;

	// row tracking
	logic [CW-1:0]           col_q;
	logic [IMAGE_ROWS_W-1:0] row_q;
	filt_t                   filt_q;

	// read stage
	logic          valid_s1;
	s1_item_t      item_s1;
	logic [AW-1:0] idx_s1;

	// output register
	logic       res_valid_s2;
	logic [7:0] out_byte_s2;
	logic       eor_s2;
	logic       eoi_s2;

	// left and upper-left pixel history
	logic [7:0] left_q [MAX_PIXEL_BYTES];
	logic [7:0] upl_q  [MAX_PIXEL_BYTES];

	logic                     cfg_wr;
	logic [RBW-1:0]           rb_ext;
	logic [RBW-1:0]           rb_eff;
	logic [RBW-1:0]           col_ext;
	logic [IMAGE_ROWS_W-1:0]  rows_eff;
	logic [IMAGE_ROWS_W-1:0]  row_inc;
	logic [PIXEL_BYTES_W-1:0] pb_eff;
	logic [PW-1:0]            pb_sel;
	logic                     accept;
	logic                     is_filter;
	logic                     last_col;
	logic                     img_end;
	logic [AW-1:0]            idx_acc;
	logic                     out_free;
	logic                     s1_go;
	logic                     wr_en;
	logic [7:0]               rd_data;
	logic [7:0]               a_byte;
	logic [7:0]               b_byte;
	logic [7:0]               c_byte;
	logic [7:0]               pred;
	logic [7:0]               res;

	// apb register writes
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q   <= ROW_BYTES_W'(1);
			pixel_bytes_q <= PIXEL_BYTES_W'(1);
			image_rows_q  <= IMAGE_ROWS_W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ROW_BYTES:   row_bytes_q   <= pwdata[ROW_BYTES_W-1:0];
				REG_PIXEL_BYTES: pixel_bytes_q <= pwdata[PIXEL_BYTES_W-1:0];
				REG_IMAGE_ROWS:  image_rows_q  <= pwdata[IMAGE_ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// apb register reads
	always_comb begin
		case (paddr[3:2])
			REG_ROW_BYTES:   prdata = 32'(row_bytes_q);
			REG_PIXEL_BYTES: prdata = 32'(pixel_bytes_q);
			REG_IMAGE_ROWS:  prdata = 32'(image_rows_q);
			default:         prdata = '0;
		endcase
	end

	// saturated geometry
	assign rb_ext   = RBW'(row_bytes_q);
	assign rb_eff   = (rb_ext == '0) ? RBW'(1) : ((rb_ext > MAX_RB) ? MAX_RB : rb_ext);
	assign rows_eff = (image_rows_q == '0) ? IMAGE_ROWS_W'(1) : image_rows_q;
	assign pb_eff   = (pixel_bytes_q == '0) ? PIXEL_BYTES_W'(1) :
		((pixel_bytes_q > MAX_PB) ? MAX_PB : pixel_bytes_q);
	assign pb_sel   = PW'(pb_eff - PIXEL_BYTES_W'(1));

	// item intake and row position
	assign out_free   = !res_valid_s2 || res_ready;
	assign s1_go      = valid_s1 && (!item_s1.is_data || out_free);
	assign byte_ready = !valid_s1 || s1_go;
	assign accept     = byte_valid && byte_ready;
	assign is_filter  = (col_q == '0);
	assign col_ext    = RBW'(col_q);
	assign last_col   = (col_ext >= rb_eff);
	assign row_inc    = row_q + IMAGE_ROWS_W'(1);
	assign img_end    = (row_inc >= rows_eff);
	assign idx_acc    = AW'(col_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			filt_q <= FILT_NONE;
		end else if (accept) begin
			if (is_filter) begin
				filt_q <= (in_byte > FILT_MAX_CODE) ? FILT_NONE : filt_t'(in_byte[2:0]);
				col_q  <= CW'(1);
			end else if (last_col) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_inc;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// read stage: item waits here while the line buffer is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.is_data <= !is_filter;
			item_s1.value   <= in_byte;
			item_s1.filt    <= filt_q;
			item_s1.top_row <= (row_q == '0);
			item_s1.eor     <= last_col;
			item_s1.eoi     <= last_col && img_end;
			idx_s1          <= idx_acc;
		end
	end

	// prior row; write-back of one item always lands before the next read of that column
	assign wr_en = valid_s1 && item_s1.is_data && out_free;

	pngsu_line_buf #(
		.DEPTH  (MAX_ROW_BYTES),
		.ADDR_W (AW)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (res),
		.rd_en   (accept && !is_filter),
		.rd_addr (idx_acc),
		.rd_data (rd_data)
	);

	// predictor and reconstruction
	assign a_byte = left_q[pb_sel];
	assign c_byte = upl_q[pb_sel];
	assign b_byte = item_s1.top_row ? 8'd0 : rd_data;

	always_comb begin
		case (item_s1.filt)
			FILT_SUB:   pred = a_byte;
			FILT_UP:    pred = b_byte;
			FILT_AVG:   pred = avg_pred(a_byte, b_byte);
			FILT_PAETH: pred = paeth_pred(a_byte, b_byte, c_byte);
			default:    pred = 8'd0;
		endcase
	end

	assign res = item_s1.value + pred;

	// pixel history, cleared by a filter item at each row start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= 8'd0;
				upl_q[i]  <= 8'd0;
			end
		end else if (s1_go) begin
			if (item_s1.is_data) begin
				for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
					left_q[i] <= left_q[i-1];
					upl_q[i]  <= upl_q[i-1];
				end
				left_q[0] <= res;
				upl_q[0]  <= b_byte;
			end else begin
				for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i] <= 8'd0;
					upl_q[i]  <= 8'd0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= valid_s1 && item_s1.is_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_byte_s2 <= res;
			eor_s2      <= item_s1.eor;
			eoi_s2      <= item_s1.eoi;
		end
	end

	assign res_valid    = res_valid_s2;
	assign out_byte     = out_byte_s2;
	assign end_of_row   = eor_s2;
	assign end_of_image = eoi_s2;

	// checks
	`PNGSU_ASSERT_NOW(a_no_same_column, wr_en && accept && !is_filter, idx_s1 != idx_acc, "line buffer read and write hit one column")
	`PNGSU_ASSERT_NEXT(a_filter_opens_row, accept && is_filter, col_q == CW'(1), "filter item did not open a row")
	`PNGSU_ASSERT_NEXT(a_s1_holds, valid_s1 && !byte_ready, valid_s1 && $stable(idx_s1), "read stage lost its item while stalled")
	`PNGSU_ASSERT_NOW(a_ready_only_full, !byte_ready, valid_s1 && item_s1.is_data && res_valid_s2, "intake stalled with room free")

endmodule

[sv/pngsu_line_buf.sv]
// prior-row line buffer: one write port, one read port with registered data
module pngsu_line_buf #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// storage array, read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the png scanline unfilter: stream driver, result monitor, predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pngsu_pkg::*;

	localparam int MAX_ROW       = 8192;
	localparam int MAX_PIX       = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 16;
	localparam int RANDOM_ITEMS  = 790;

	// one reconstructed byte as the block should emit it
	typedef struct packed {
		logic [7:0] data;
		logic       row_end;
		logic       image_end;
	} raw_byte_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// block ports
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  in_byte = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        end_of_row;
	logic        end_of_image;

	png_scanline_unfilter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.in_byte      (in_byte),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.out_byte     (out_byte),
		.end_of_row   (end_of_row),
		.end_of_image (end_of_image)
	);

	// register shadow, written only while the block is idle
	logic [ROW_BYTES_W-1:0]   row_bytes_cfg = 1;
	logic [PIXEL_BYTES_W-1:0] pixel_bytes_cfg = 1;
	logic [IMAGE_ROWS_W-1:0]  image_rows_cfg = 1;

	// predictor state
	logic [7:0]  line_buf [0:MAX_ROW-1];
	logic [7:0]  left_px [0:MAX_PIX-1];
	logic [7:0]  upleft_px [0:MAX_PIX-1];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	filt_t       filter_now = FILT_NONE;

	// stream bytes waiting to be sent, reconstructed bytes still due
	logic [7:0] stream_bytes [$];
	raw_byte_t  raw_bytes_due [$];
	raw_byte_t  got_due;

	// position of the generator in the stream, ahead of the block
	int unsigned gen_col = 0;
	int unsigned gen_row = 0;

	// idling and stall control
	int unsigned source_max_gap = 0;
	int unsigned sink_max_gap = 0;
	int unsigned source_wait = 0;
	int unsigned sink_wait = 0;
	int unsigned hold_left = 0;
	int          hold_asked = 0;
	int          hold_served = 0;

	// bookkeeping
	int mismatch_count = 0;
	int items_queued = 0;
	int items_taken = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;

	// effective register values after saturation
	function automatic int unsigned lim_row_bytes();
		if (row_bytes_cfg == 0) return 1;
		if (row_bytes_cfg > MAX_ROW) return MAX_ROW;
		return row_bytes_cfg;
	endfunction

	function automatic int unsigned lim_pixel_bytes();
		if (pixel_bytes_cfg == 0) return 1;
		if (pixel_bytes_cfg > MAX_PIX) return MAX_PIX;
		return pixel_bytes_cfg;
	endfunction

	function automatic int unsigned lim_image_rows();
		return (image_rows_cfg == 0) ? 1 : image_rows_cfg;
	endfunction

	// paeth: nearest of left, above, upper-left to left + above - upper-left
	function automatic logic [7:0] paeth_choice(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		int ia, ib, ic, est, da, db, dc;
		ia = a;
		ib = b;
		ic = c;
		est = ia + ib - ic;
		da = est - ia;
		db = est - ib;
		dc = est - ic;
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) return a;
		if (db <= dc) return b;
		return c;
	endfunction

	// reconstruct one accepted stream byte and queue its result, if any
	function automatic void unfilter_byte(input logic [7:0] v);
		int unsigned rb, pb, idx;
		int k;
		logic [7:0] a, b, c, guess;
		logic [8:0] pair_sum;
		raw_byte_t due;
		rb = lim_row_bytes();
		pb = lim_pixel_bytes();
		// filter code starts a row
		if (col_pos == 0) begin
			filter_now = (v > FILT_MAX_CODE) ? FILT_NONE : filt_t'(v[2:0]);
			for (k = 0; k < MAX_PIX; k++) begin
				left_px[k] = 8'd0;
				upleft_px[k] = 8'd0;
			end
			col_pos = 1;
			return;
		end
		idx = (col_pos - 1 >= MAX_ROW) ? MAX_ROW - 1 : col_pos - 1;
		a = left_px[pb - 1];
		c = upleft_px[pb - 1];
		b = (row_pos == 0) ? 8'd0 : line_buf[idx];
		case (filter_now)
			FILT_SUB: guess = a;
			FILT_UP: guess = b;
			FILT_AVG: begin
				pair_sum = {1'b0, a} + {1'b0, b};
				guess = pair_sum[8:1];
			end
			FILT_PAETH: guess = paeth_choice(a, b, c);
			default: guess = 8'd0;
		endcase
		due.data = v + guess;
		// shift the one-pixel history
		for (k = MAX_PIX - 1; k > 0; k--) begin
			left_px[k] = left_px[k - 1];
			upleft_px[k] = upleft_px[k - 1];
		end
		left_px[0] = due.data;
		upleft_px[0] = b;
		line_buf[idx] = due.data;
		due.row_end = (idx + 1 >= rb);
		due.image_end = 1'b0;
		if (due.row_end) begin
			col_pos = 0;
			row_pos = (row_pos + 1) & 32'hFFFF;
			if (row_pos >= lim_image_rows()) begin
				row_pos = 0;
				due.image_end = 1'b1;
			end
		end else begin
			col_pos++;
		end
		raw_bytes_due.push_back(due);
	endfunction

	task automatic report_mismatch(input string field, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: bad %s, got %h, want %h", $time, field, got, want);
		mismatch_count++;
	endtask

	// stimulus helpers
	function automatic logic [7:0] pick_data();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 3));
			1: return $urandom_range(0, 1) ? 8'hFF : 8'h80;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [7:0] pick_filter();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(int'(FILT_MAX_CODE) + 1, 255));
		return 8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH)));
	endfunction

	// queue one stream byte and track where the stream stands
	function automatic void push_byte(input logic [7:0] v);
		stream_bytes.push_back(v);
		items_queued++;
		if (gen_col == 0) begin
			gen_col = 1;
		end else if (gen_col >= lim_row_bytes()) begin
			gen_col = 0;
			gen_row = (gen_row + 1) & 32'hFFFF;
			if (gen_row >= lim_image_rows()) gen_row = 0;
		end else begin
			gen_col++;
		end
	endfunction

	function automatic void push_row(input logic [7:0] code);
		push_byte(code);
		while (gen_col != 0) push_byte(pick_data());
	endfunction

	// complete the current row and image
	function automatic void finish_image();
		while (gen_col != 0) push_byte(pick_data());
		while (gen_row != 0) push_row(pick_filter());
	endfunction

	function automatic void push_image();
		push_row(pick_filter());
		finish_image();
	endfunction

	// apb write: setup then access, ends on a falling edge
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ROW_BYTES: row_bytes_cfg = value[ROW_BYTES_W-1:0];
			REG_PIXEL_BYTES: pixel_bytes_cfg = value[PIXEL_BYTES_W-1:0];
			REG_IMAGE_ROWS: image_rows_cfg = value[IMAGE_ROWS_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic pick_idling();
		@(negedge clk);
		source_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 7;
		sink_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 7;
	endtask

	// sender holds off until every result is in and the block has settled
	task automatic wait_drained();
		do @(negedge clk);
		while (stream_bytes.size() != 0 || byte_valid || raw_bytes_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// stream driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			in_byte <= 8'd0;
		end else begin
			if (byte_valid && byte_ready) begin
				unfilter_byte(in_byte);
				items_taken++;
				source_wait = $urandom_range(0, source_max_gap);
			end
			if (!byte_valid || byte_ready) begin
				if (source_wait > 0) begin
					source_wait--;
					byte_valid <= 1'b0;
				end else if (stream_bytes.size() != 0) begin
					byte_valid <= 1'b1;
					in_byte <= stream_bytes.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and sink stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				results_seen++;
				if (raw_bytes_due.size() == 0) begin
					report_mismatch("result with nothing due", out_byte, 8'd0);
				end else begin
					got_due = raw_bytes_due.pop_front();
					if (out_byte !== got_due.data)
						report_mismatch("out_byte", out_byte, got_due.data);
					if (end_of_row !== got_due.row_end)
						report_mismatch("end_of_row", 8'(end_of_row), 8'(got_due.row_end));
					if (end_of_image !== got_due.image_end)
						report_mismatch("end_of_image", 8'(end_of_image),
							8'(got_due.image_end));
				end
				sink_wait = $urandom_range(0, sink_max_gap);
			end
			// long hold-off so the block backs up into its input
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (res_valid && res_ready) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		int unsigned rb_pick, pb_pick, rows_pick, images;
		int start_count, phase_no;
		foreach (line_buf[i]) line_buf[i] = 8'd0;
		foreach (left_px[i]) begin
			left_px[i] = 8'd0;
			upleft_px[i] = 8'd0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: one-byte rows, one-row images, unknown codes
		pick_idling();
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(FILT_MAX_CODE + 8'd1);
		push_byte(8'h01);
		push_byte(8'(FILT_PAETH));
		push_byte(8'hFF);
		wait_drained();

		// every filter over extreme bytes, two-byte pixels
		write_reg(REG_ROW_BYTES, 32'd3);
		write_reg(REG_PIXEL_BYTES, 32'd2);
		write_reg(REG_IMAGE_ROWS, 32'd5);
		pick_idling();
		push_byte(8'(FILT_NONE));
		push_byte(8'hFF); push_byte(8'h00); push_byte(8'h80);
		push_byte(8'(FILT_UP));
		push_byte(8'h01); push_byte(8'hFF); push_byte(8'h7F);
		push_byte(8'(FILT_AVG));
		push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h01);
		push_byte(8'(FILT_PAETH));
		push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
		push_byte(8'(FILT_SUB));
		push_byte(8'hFF); push_byte(8'h01); push_byte(8'hFE);
		wait_drained();

		// row length cut below the current column mid-row
		write_reg(REG_ROW_BYTES, 32'd6);
		write_reg(REG_IMAGE_ROWS, 32'd3);
		pick_idling();
		push_byte(8'(FILT_PAETH));
		repeat (4) push_byte(pick_data());
		wait_drained();
		write_reg(REG_ROW_BYTES, 32'd3);
		finish_image();
		wait_drained();

		// zero registers act as one
		write_reg(REG_ROW_BYTES, 32'd0);
		write_reg(REG_PIXEL_BYTES, 32'd0);
		write_reg(REG_IMAGE_ROWS, 32'd0);
		pick_idling();
		repeat (3) push_image();
		wait_drained();

		// tallest image setting, then shrunk below the row already reached
		write_reg(REG_ROW_BYTES, 32'd1);
		write_reg(REG_PIXEL_BYTES, 32'd15);
		write_reg(REG_IMAGE_ROWS, 32'hFFFF);
		pick_idling();
		repeat (6) push_row(pick_filter());
		wait_drained();
		write_reg(REG_IMAGE_ROWS, 32'd3);
		write_reg(REG_PIXEL_BYTES, 32'd8);
		finish_image();
		wait_drained();

		// random settings, whole images per setting
		start_count = items_queued;
		phase_no = 0;
		while (items_queued - start_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: rb_pick = $urandom_range(25, 400);
				1: rb_pick = 0;
				default: rb_pick = $urandom_range(1, 24);
			endcase
			case ($urandom_range(0, 9))
				0: pb_pick = 0;
				1: pb_pick = $urandom_range(MAX_PIX + 1, 15);
				default: pb_pick = $urandom_range(1, MAX_PIX);
			endcase
			rows_pick = (rb_pick > 24) ? $urandom_range(1, 2) : $urandom_range(0, 4);
			images = (rb_pick > 24) ? 1 : $urandom_range(1, 3);
			// bits above each field are ignored by the block
			write_reg(REG_ROW_BYTES, rb_pick | ($urandom() << ROW_BYTES_W));
			write_reg(REG_PIXEL_BYTES, pb_pick | ($urandom() << PIXEL_BYTES_W));
			write_reg(REG_IMAGE_ROWS, rows_pick | ($urandom() << IMAGE_ROWS_W));
			pick_idling();
			repeat (images) push_image();
			if (phase_no == 0 || $urandom_range(0, 5) == 0) hold_asked++;
			wait_drained();
			phase_no++;
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("%0d stream items taken, %0d bytes checked, %0d register writes",
			items_taken, results_seen, reg_writes);
		$display("covered all filters, unknown codes, saturated and mid-row register changes, "
			, "random geometry and long result stalls");
		if (mismatch_count == 0 && raw_bytes_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
